// ===== design/rdc_pkg.sv =====
// Shared types and constants for the radix digit converter.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
package rdc_pkg;

  localparam int IN_W        = 32;
  localparam int SYM_W       = 8;
  localparam int SYM_COUNT   = 16;
  localparam int DIGIT_W     = 4;
  localparam int STACK_DEPTH = 32;
  localparam int COUNT_W     = 6;
  localparam int BASE_W      = 5;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;

  localparam logic [SYM_W-1:0] SIGN_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SIGN_MINUS = 8'h2D;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

  typedef logic [SYM_COUNT-1:0][SYM_W-1:0] sym_array_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic run;
  } div_ctrl_t;

  typedef struct packed {
    logic done;
    logic quot_zero;
  } div_stat_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctrl_t;

endpackage

// ===== design/rdc_alpha.sv =====
// Alphabet checker: radix range, sign symbols and repeated symbols.
// Depends on rdc_pkg.
`timescale 1ns / 1ps
module rdc_alpha #(
  parameter int MAX_SYMBOLS = 16
) (
  input  logic [rdc_pkg::BASE_W-1:0] base_length,
  input  rdc_pkg::sym_array_t        syms,
  output logic                       ok
);
  import rdc_pkg::*;

  always_comb begin
    logic bad;
    bad = 1'b0;
    if (base_length < BASE_W'(2) || base_length > BASE_W'(MAX_SYMBOLS)) begin
      bad = 1'b1;
    end
    for (int i = 0; i < SYM_COUNT; i++) begin
      if (BASE_W'(i) < base_length) begin
        if (syms[i] == SIGN_PLUS || syms[i] == SIGN_MINUS) begin
          bad = 1'b1;
        end
        for (int j = i + 1; j < SYM_COUNT; j++) begin
          if (BASE_W'(j) < base_length && syms[i] == syms[j]) begin
            bad = 1'b1;
          end
        end
      end
    end
    ok = !bad;
  end

endmodule

// ===== design/rdc_div.sv =====
// Digit-serial divider: divides the magnitude by the radix, four bits per cycle,
// leaving the quotient in place and the remainder as the next digit.
// Depends on rdc_pkg.
`timescale 1ns / 1ps
module rdc_div #(
  parameter int MAG_W = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rdc_pkg::div_ctrl_t          ctrl,
  input  logic [MAG_W-1:0]            mag,
  input  logic [rdc_pkg::BASE_W-1:0]  radix,
  output rdc_pkg::div_stat_t          stat,
  output logic [rdc_pkg::DIGIT_W-1:0] digit
);
  import rdc_pkg::*;

  localparam int NIB   = MAG_W / 4;
  localparam int CNT_W = (NIB > 1) ? $clog2(NIB) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NIB - 1);

  logic [MAG_W-1:0]   quot;
  logic [MAG_W-1:0]   quot_next;
  logic [DIGIT_W-1:0] rem;
  logic [DIGIT_W-1:0] rem_step;
  logic [CNT_W-1:0]   cnt;

  always_comb begin
    logic [BASE_W-1:0] r;
    logic [3:0]        qn;
    r  = {1'b0, rem};
    qn = '0;
    for (int k = 3; k >= 0; k--) begin
      r = {r[3:0], quot[MAG_W-4+k]};
      if (r >= radix) begin
        r     = r - radix;
        qn[k] = 1'b1;
      end
    end
    rem_step  = r[DIGIT_W-1:0];
    quot_next = {quot[MAG_W-5:0], qn};
  end

  assign digit          = rem_step;
  assign stat.done      = (cnt == CNT_LAST);
  assign stat.quot_zero = (quot_next == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.load) begin
      cnt <= '0;
    end else if (ctrl.run) begin
      cnt <= (cnt == CNT_LAST) ? '0 : cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      quot <= mag;
      rem  <= '0;
    end else if (ctrl.run) begin
      quot <= quot_next;
      rem  <= (cnt == CNT_LAST) ? '0 : rem_step;
    end
  end

endmodule

// ===== design/rdc_stack.sv =====
// Digit stack as a shift register: push shifts in at the top, pop shifts out.
// Depends on rdc_pkg.
`timescale 1ns / 1ps
module rdc_stack (
  input  logic                        clk,
  input  rdc_pkg::stack_ctrl_t        ctrl,
  input  logic [rdc_pkg::DIGIT_W-1:0] din,
  output logic [rdc_pkg::DIGIT_W-1:0] top
);
  import rdc_pkg::*;

  logic [DIGIT_W-1:0] st [STACK_DEPTH];

  assign top = st[0];

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      st[0] <= din;
      for (int i = 1; i < STACK_DEPTH; i++) begin
        st[i] <= st[i-1];
      end
    end else if (ctrl.pop) begin
      for (int i = 0; i < STACK_DEPTH - 1; i++) begin
        st[i] <= st[i+1];
      end
    end
  end

endmodule

// ===== design/radix_digit_converter_unit.sv =====
// Radix digit converter top level: config registers, sequencer, output register.
// Depends on rdc_pkg, rdc_alpha, rdc_div and rdc_stack.
// One value at a time: accept, alphabet check, then one divider pass per digit,
// then one emitted symbol per cycle while the output is taken.
// Synchronous reset clears config registers, sequencer and output valid.
`timescale 1ns / 1ps
module radix_digit_converter_unit #(
  parameter int MAX_SYMBOLS = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [rdc_pkg::IN_W-1:0]      s_tdata,   // [31:0] value
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [rdc_pkg::SYM_W-1:0]     m_tdata,   // [7:0] symbol
  output logic                          m_tlast,
  input  logic                          cfg_we,
  input  logic [rdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rdc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rdc_pkg::*;

  localparam int MAG_W = ((VALUE_WIDTH + 3) / 4) * 4;

  logic [BASE_W-1:0]     base_length;
  logic [CFG_DATA_W-1:0] symbols_low;
  logic [CFG_DATA_W-1:0] symbols_high;
  sym_array_t            syms;
  logic                  alpha_ok;

  state_t                state, state_next;
  logic                  negative, negative_next;
  logic [COUNT_W-1:0]    count, count_next;

  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag_abs;
  div_ctrl_t              div_ctrl;
  div_stat_t              div_stat;
  logic [DIGIT_W-1:0]     digit;
  stack_ctrl_t            stk_ctrl;
  logic [DIGIT_W-1:0]     stk_top;

  logic                   out_free;
  logic                   out_load;
  logic [SYM_W-1:0]       out_sym;
  logic                   out_last;

  assign syms    = {symbols_high, symbols_low};
  assign raw     = s_tdata[VALUE_WIDTH-1:0];
  assign mag_abs = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_length  <= '0;
      symbols_low  <= '0;
      symbols_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_LENGTH:  base_length  <= cfg_data[BASE_W-1:0];
        CFG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        CFG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        default: ;
      endcase
    end
  end

  rdc_alpha #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_alpha (
    .base_length(base_length),
    .syms       (syms),
    .ok         (alpha_ok)
  );

  rdc_div #(
    .MAG_W(MAG_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .ctrl (div_ctrl),
    .mag  (MAG_W'(mag_abs)),
    .radix(base_length),
    .stat (div_stat),
    .digit(digit)
  );

  rdc_stack u_stack (
    .clk (clk),
    .ctrl(stk_ctrl),
    .din (digit),
    .top (stk_top)
  );

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next    = state;
    negative_next = negative;
    count_next    = count;
    div_ctrl      = '0;
    stk_ctrl      = '0;
    out_load      = 1'b0;
    out_sym       = syms[stk_top];
    out_last      = (count == COUNT_W'(1));
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          div_ctrl.load = 1'b1;
          negative_next = raw[VALUE_WIDTH-1];
          count_next    = '0;
          state_next    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = alpha_ok ? ST_DIVIDE : ST_IDLE;
      end
      ST_DIVIDE: begin
        div_ctrl.run = 1'b1;
        if (div_stat.done) begin
          stk_ctrl.push = 1'b1;
          count_next    = count + COUNT_W'(1);
          if (div_stat.quot_zero || count == COUNT_W'(STACK_DEPTH - 1)) begin
            state_next = negative ? ST_SIGN : ST_EMIT;
          end
        end
      end
      ST_SIGN: begin
        out_sym  = SIGN_MINUS;
        out_last = 1'b0;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          stk_ctrl.pop = 1'b1;
          count_next   = count - COUNT_W'(1);
          if (count == COUNT_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      negative <= 1'b0;
      count    <= '0;
    end else begin
      state    <= state_next;
      negative <= negative_next;
      count    <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= out_sym;
      m_tlast <= out_last;
    end
  end

endmodule
